// ----- src/d2q9_pkg.sv -----
// Shared types, constants and helpers for the D2Q9 BGK collision node.
// No dependencies; used by d2q9_moments and d2q9_bgk_collision_node.
package d2q9_pkg;

  localparam int VALUE_BITS    = 24;
  localparam int FRACTION_BITS = 20;
  localparam int NUM_DIRS      = 9;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef val_t [NUM_DIRS-1:0] dist_t;

  // node kinds
  localparam logic [1:0] KIND_FLUID  = 2'd0;
  localparam logic [1:0] KIND_SOLID  = 2'd1;
  localparam logic [1:0] KIND_INLET  = 2'd2;
  localparam logic [1:0] KIND_OUTLET = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_RELAX_RATE   = 2'd0;
  localparam logic [1:0] REG_INLET_SCALE  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_SPAN = 2'd2;

  localparam logic [21:0] RELAX_RATE_RESET   = 22'd1048576;
  localparam logic [22:0] INLET_SCALE_RESET  = 23'd0;
  localparam logic [9:0]  CHANNEL_SPAN_RESET = 10'd255;

  localparam int DIR_X [NUM_DIRS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NUM_DIRS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  typedef struct packed {
    val_t       dist_rest;
    val_t       dist_east;
    val_t       dist_north;
    val_t       dist_west;
    val_t       dist_south;
    val_t       dist_northeast;
    val_t       dist_northwest;
    val_t       dist_southwest;
    val_t       dist_southeast;
    logic [1:0] node_kind;
    logic [9:0] row_index;
  } node_t;

  typedef struct packed {
    val_t post_rest;
    val_t post_east;
    val_t post_north;
    val_t post_west;
    val_t post_south;
    val_t post_northeast;
    val_t post_northwest;
    val_t post_southwest;
    val_t post_southeast;
    val_t pressure;
    val_t velocity_x;
    val_t velocity_y;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    val_t       p;
    val_t       ux;
    val_t       uy;
  } moment_t;

  localparam logic signed [47:0] SAT_HI = 48'sd8388607;
  localparam logic signed [47:0] SAT_LO = -48'sd8388608;

  function automatic val_t sat24(input logic signed [47:0] v);
    val_t r;
    if (v > SAT_HI) begin
      r = 24'sh7fffff;
    end else if (v < SAT_LO) begin
      r = 24'sh800000;
    end else begin
      r = v[VALUE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/d2q9_moments.sv -----
// Moment stages (two pipeline registers): direction sums, pressure divide
// by three, inlet profile, node-kind masking. Depends on d2q9_pkg.
module d2q9_moments import d2q9_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  node_t       node,
  input  logic [22:0] inlet_scale,
  input  logic [9:0]  channel_span,
  output moment_t     mom,
  output dist_t       dirs
);

  // reciprocal of 6 at 2^34, exact for 31-bit dividends
  localparam logic [31:0] RECIP6 = 32'd2863311531;
  localparam logic signed [31:0] P_OFFSET = 32'sd805306368; // 6 * 2^27

  dist_t f_in;
  logic signed [27:0] sum_c, sx_c, sy_c;
  logic signed [31:0] pnum_c;
  logic signed [11:0] diff_c;
  logic signed [21:0] prof_c;

  logic               v1;
  dist_t              f1;
  logic [1:0]         kind1;
  logic [30:0]        pnum1;
  logic signed [27:0] sx1, sy1;
  logic signed [21:0] prof1;

  logic [62:0]        pq_c;
  logic signed [29:0] praw_c;
  logic signed [45:0] inlet_c;
  val_t               p_c, ux_c, uy_c;

  assign f_in[0] = node.dist_rest;
  assign f_in[1] = node.dist_east;
  assign f_in[2] = node.dist_north;
  assign f_in[3] = node.dist_west;
  assign f_in[4] = node.dist_south;
  assign f_in[5] = node.dist_northeast;
  assign f_in[6] = node.dist_northwest;
  assign f_in[7] = node.dist_southwest;
  assign f_in[8] = node.dist_southeast;

  always_comb begin
    sum_c = '0;
    sx_c  = '0;
    sy_c  = '0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      sum_c = sum_c + 28'($signed(f_in[i]));
      if (DIR_X[i] == 1) begin
        sx_c = sx_c + 28'($signed(f_in[i]));
      end else if (DIR_X[i] == -1) begin
        sx_c = sx_c - 28'($signed(f_in[i]));
      end
      if (DIR_Y[i] == 1) begin
        sy_c = sy_c + 28'($signed(f_in[i]));
      end else if (DIR_Y[i] == -1) begin
        sy_c = sy_c - 28'($signed(f_in[i]));
      end
    end
    // nearest of sum/3 = floor((2*sum + 3) / 6), shifted positive
    pnum_c = 32'(sum_c) * 32'sd2 + 32'sd3 + P_OFFSET;
    diff_c = $signed({2'b00, channel_span}) - $signed({2'b00, node.row_index});
    prof_c = 22'($signed({1'b0, node.row_index})) * 22'(diff_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      f1    <= f_in;
      kind1 <= node.node_kind;
      pnum1 <= pnum_c[30:0];
      sx1   <= sx_c;
      sy1   <= sy_c;
      prof1 <= prof_c;
    end
  end

  always_comb begin
    pq_c    = 63'(pnum1) * 63'(RECIP6);
    praw_c  = $signed({1'b0, pq_c[62:34]}) - 30'sd134217728;
    inlet_c = 46'($signed({1'b0, inlet_scale})) * 46'(prof1);
    p_c  = sat24(48'(praw_c));
    ux_c = sat24(48'(sx1));
    uy_c = sat24(48'(sy1));
    case (kind1)
      KIND_SOLID: begin
        p_c  = '0;
        ux_c = '0;
        uy_c = '0;
      end
      KIND_INLET: begin
        ux_c = sat24(48'(inlet_c));
        uy_c = '0;
      end
      KIND_OUTLET: begin
        p_c = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mom.valid <= 1'b0;
    end else if (adv) begin
      mom.valid <= v1;
    end
    if (adv) begin
      mom.kind <= kind1;
      mom.p    <= p_c;
      mom.ux   <= ux_c;
      mom.uy   <= uy_c;
      dirs     <= f1;
    end
  end

endmodule

// ----- src/d2q9_bgk_collision_node.sv -----
// D2Q9 BGK collision node, top level: APB registers, square, equilibrium
// and relaxation stages. Depends on d2q9_pkg and d2q9_moments.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------
//  node    | node_valid   | node_stall   | node   (node_t, one request)
//  result  | result_valid | result_stall | result (result_t)
//  config  | APB write/read, paddr[3:2] selects the register
//
// Seven register stages: two moment stages, squares, equilibrium bracket,
// weight divide, relax multiply, output register. One node enters per
// cycle while not held. The whole pipe holds while the output register
// is full and stalled; node_stall is asserted only then. Reset clears the
// valid bits and loads the register reset values.
module d2q9_bgk_collision_node import d2q9_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        node_valid,
  output logic        node_stall,
  input  node_t       node,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // reciprocal of 9 at 2^36: serves /18 at 2^37 and /72 at 2^39
  localparam logic [32:0] RECIP9 = 33'd7635497416;

  logic [21:0] relax_rate;
  logic [22:0] inlet_scale;
  logic [9:0]  channel_span;

  logic adv;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate   <= RELAX_RATE_RESET;
      inlet_scale  <= INLET_SCALE_RESET;
      channel_span <= CHANNEL_SPAN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RELAX_RATE:   relax_rate   <= pwdata[21:0];
        REG_INLET_SCALE:  inlet_scale  <= pwdata[22:0];
        REG_CHANNEL_SPAN: channel_span <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RELAX_RATE:   prdata = {10'd0, relax_rate};
      REG_INLET_SCALE:  prdata = {9'd0, inlet_scale};
      REG_CHANNEL_SPAN: prdata = {22'd0, channel_span};
      default:          prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // one global advance: the pipe moves unless the output is full and held
  assign adv        = !(result_valid && result_stall);
  assign node_stall = result_valid && result_stall;

  // ---------------- stages 1-2: moments ----------------
  moment_t m2;
  dist_t   f2;

  d2q9_moments u_moments (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (node_valid),
    .node         (node),
    .inlet_scale  (inlet_scale),
    .channel_span (channel_span),
    .mom          (m2),
    .dirs         (f2)
  );

  // ---------------- stage 3: squares ----------------
  logic signed [24:0] upl_c, umi_c;
  moment_t            m3;
  dist_t              f3;
  logic signed [49:0] sqx3, sqy3, sqp3, sqm3;

  assign upl_c = 25'(m2.ux) + 25'(m2.uy);
  assign umi_c = 25'(m2.ux) - 25'(m2.uy);

  always_ff @(posedge clk) begin
    if (rst) begin
      m3.valid <= 1'b0;
    end else if (adv) begin
      m3.valid <= m2.valid;
    end
    if (adv) begin
      m3.kind <= m2.kind;
      m3.p    <= m2.p;
      m3.ux   <= m2.ux;
      m3.uy   <= m2.uy;
      f3      <= f2;
      sqx3    <= 50'(m2.ux) * 50'(m2.ux);
      sqy3    <= 50'(m2.uy) * 50'(m2.uy);
      sqp3    <= 50'(upl_c) * 50'(upl_c);
      sqm3    <= 50'(umi_c) * 50'(umi_c);
    end
  end

  // ---------------- stage 4: equilibrium bracket ----------------
  // inner is clamped to a bound past which the weighted value saturates
  // anyway, then shifted positive for the constant divide.
  logic signed [53:0] usq_n, tx_n, ty_n, tp_n, tm_n;
  logic signed [39:0] usq_t, tx_t, ty_t, tp_t, tm_t;
  logic signed [39:0] a_c   [NUM_DIRS];
  logic signed [39:0] sq_c  [NUM_DIRS];
  logic signed [39:0] inner_c [NUM_DIRS];
  logic signed [39:0] lim_c, clamp_c, num_c;
  logic [31:0]        ynum_c [NUM_DIRS];
  moment_t            m4;
  dist_t              f4;
  logic [31:0]        ynum4 [NUM_DIRS];

  always_comb begin
    usq_n = (54'(sqx3 + sqy3) * 54'sd3 + 54'sd1048576) >>> (FRACTION_BITS + 1);
    tx_n  = (54'(sqx3) * 54'sd9 + 54'sd1048576) >>> (FRACTION_BITS + 1);
    ty_n  = (54'(sqy3) * 54'sd9 + 54'sd1048576) >>> (FRACTION_BITS + 1);
    tp_n  = (54'(sqp3) * 54'sd9 + 54'sd1048576) >>> (FRACTION_BITS + 1);
    tm_n  = (54'(sqm3) * 54'sd9 + 54'sd1048576) >>> (FRACTION_BITS + 1);
    usq_t = usq_n[39:0];
    tx_t  = tx_n[39:0];
    ty_t  = ty_n[39:0];
    tp_t  = tp_n[39:0];
    tm_t  = tm_n[39:0];

    a_c[0] = '0;                          sq_c[0] = '0;
    a_c[1] = 40'(m3.ux);                  sq_c[1] = tx_t;
    a_c[2] = 40'(m3.uy);                  sq_c[2] = ty_t;
    a_c[3] = -40'(m3.ux);                 sq_c[3] = tx_t;
    a_c[4] = -40'(m3.uy);                 sq_c[4] = ty_t;
    a_c[5] = 40'(m3.ux) + 40'(m3.uy);     sq_c[5] = tp_t;
    a_c[6] = 40'(m3.uy) - 40'(m3.ux);     sq_c[6] = tm_t;
    a_c[7] = -(40'(m3.ux) + 40'(m3.uy));  sq_c[7] = tp_t;
    a_c[8] = 40'(m3.ux) - 40'(m3.uy);     sq_c[8] = tm_t;

    for (int i = 0; i < NUM_DIRS; i++) begin
      inner_c[i] = 40'sd3 * 40'(m3.p) + 40'sd3 * a_c[i] + sq_c[i] - usq_t;
      if (i == 0) begin
        lim_c = 40'sd33554432;     // rest, weight 4/9
      end else if (i < 5) begin
        lim_c = 40'sd134217728;    // axis, weight 1/9
      end else begin
        lim_c = 40'sd536870912;    // diagonal, weight 1/36
      end
      if (inner_c[i] > lim_c) begin
        clamp_c = lim_c;
      end else if (inner_c[i] < -lim_c) begin
        clamp_c = -lim_c;
      end else begin
        clamp_c = inner_c[i];
      end
      // nearest of num*inner/den = floor((2*num*inner + den) / (2*den))
      if (i == 0) begin
        num_c = clamp_c * 40'sd8 + 40'sd9 + 40'sd301989888;   // 18 * 2^24
      end else if (i < 5) begin
        num_c = clamp_c * 40'sd2 + 40'sd9 + 40'sd301989888;
      end else begin
        num_c = clamp_c * 40'sd2 + 40'sd36 + 40'sd1207959552; // 72 * 2^24
      end
      ynum_c[i] = num_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4.valid <= 1'b0;
    end else if (adv) begin
      m4.valid <= m3.valid;
    end
    if (adv) begin
      m4.kind <= m3.kind;
      m4.p    <= m3.p;
      m4.ux   <= m3.ux;
      m4.uy   <= m3.uy;
      f4      <= f3;
      ynum4   <= ynum_c;
    end
  end

  // ---------------- stage 5: weight divide, difference ----------------
  logic [64:0]        yq_c   [NUM_DIRS];
  logic [27:0]        q_c    [NUM_DIRS];
  val_t               feq_c  [NUM_DIRS];
  moment_t            m5;
  dist_t              f5;
  logic signed [24:0] d5 [NUM_DIRS];

  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      yq_c[i] = 65'(ynum4[i]) * 65'(RECIP9);
      if (i < 5) begin
        q_c[i] = yq_c[i][64:37];
      end else begin
        q_c[i] = {2'b00, yq_c[i][64:39]};
      end
      feq_c[i] = sat24(48'($signed({1'b0, q_c[i]})) - 48'sd16777216);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m5.valid <= 1'b0;
    end else if (adv) begin
      m5.valid <= m4.valid;
    end
    if (adv) begin
      m5.kind <= m4.kind;
      m5.p    <= m4.p;
      m5.ux   <= m4.ux;
      m5.uy   <= m4.uy;
      f5      <= f4;
      for (int i = 0; i < NUM_DIRS; i++) begin
        d5[i] <= 25'($signed(f4[i])) - 25'(feq_c[i]);
      end
    end
  end

  // ---------------- stage 6: relax multiply ----------------
  moment_t            m6;
  dist_t              f6;
  logic signed [47:0] pr6 [NUM_DIRS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m6.valid <= 1'b0;
    end else if (adv) begin
      m6.valid <= m5.valid;
    end
    if (adv) begin
      m6.kind <= m5.kind;
      m6.p    <= m5.p;
      m6.ux   <= m5.ux;
      m6.uy   <= m5.uy;
      f6      <= f5;
      for (int i = 0; i < NUM_DIRS; i++) begin
        pr6[i] <= 48'(d5[i]) * 48'($signed({1'b0, relax_rate}));
      end
    end
  end

  // ---------------- stage 7: round, subtract, output register ----------------
  logic signed [47:0] dl_c   [NUM_DIRS];
  val_t               post_c [NUM_DIRS];
  logic [1:0]         kind7;

  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      dl_c[i]   = (pr6[i] + 48'sd524288) >>> FRACTION_BITS;
      post_c[i] = sat24(48'($signed(f6[i])) - dl_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= m6.valid;
    end
    if (adv) begin
      kind7                 <= m6.kind;
      result.post_rest      <= post_c[0];
      result.post_east      <= post_c[1];
      result.post_north     <= post_c[2];
      result.post_west      <= post_c[3];
      result.post_south     <= post_c[4];
      result.post_northeast <= post_c[5];
      result.post_northwest <= post_c[6];
      result.post_southwest <= post_c[7];
      result.post_southeast <= post_c[8];
      result.pressure       <= m6.p;
      result.velocity_x     <= m6.ux;
      result.velocity_y     <= m6.uy;
    end
  end

`ifndef SYNTH
  a_solid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind7 == KIND_SOLID) |->
      (result.pressure == 0) && (result.velocity_x == 0) && (result.velocity_y == 0))
    else $error("solid node with nonzero moment");

  a_inlet_uy: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind7 == KIND_INLET) |-> (result.velocity_y == 0))
    else $error("inlet node with nonzero vertical velocity");

  a_outlet_p: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind7 == KIND_OUTLET) |-> (result.pressure == 0))
    else $error("outlet node with nonzero pressure");
`endif

endmodule
